// ===== rtl/three_axis_fixed_step_interpolator_macros.svh =====
// Assertion macros for the three-axis interpolator checker.
// No dependencies; taken in by the checker file.
`ifndef THREE_AXIS_FIXED_STEP_INTERPOLATOR_MACROS_SVH
`define THREE_AXIS_FIXED_STEP_INTERPOLATOR_MACROS_SVH

// Same-cycle implication.
`define TFSI_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TFSI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tfsi_pkg.sv =====
// Shared constants and types for the three-axis interpolator.
// No dependencies; used by every other file in rtl but the macro header.
package tfsi_pkg;

   localparam int AXIS_COUNT_DEF  = 3;
   localparam int COUNT_WIDTH_DEF = 32;
   localparam int FIELD_W         = 32;
   localparam int STEP_W          = 31;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic done;
      logic rem_nz;
   } mdv_status_type;

endpackage

// ===== rtl/tfsi_muldiv.sv =====
// Bit-serial unit: floor(a * b / d) with a remainder-nonzero flag.
// Shift-add multiply then restoring divide, one bit per cycle. Uses tfsi_pkg.
module tfsi_muldiv #(
   parameter int CW = tfsi_pkg::COUNT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [CW-1:0]                 a,
   input  logic [CW-1:0]                 b,
   input  logic [tfsi_pkg::FIELD_W-1:0]  d,
   output logic [CW-1:0]                 quo,
   output tfsi_pkg::mdv_status_type      status
);
   import tfsi_pkg::*;

   localparam int CNTW = $clog2(CW);
   localparam int CMPW = (CW + 1 > FIELD_W) ? CW + 1 : FIELD_W;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_MUL  = 3'b010,
      PH_DIV  = 3'b100
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [CNTW-1:0]    cnt_ff, cnt_in;
   logic [2*CW-1:0]    prod_ff, prod_in;
   logic [CW-1:0]      a_ff, a_in;
   logic [FIELD_W-1:0] d_ff, d_in;
   logic               done_ff, done_in;

   logic [CW:0]        sum;
   logic [CW:0]        trial;
   logic [CMPW-1:0]    trial_ext;
   logic [CMPW-1:0]    d_ext;
   logic               ge;
   logic [CW-1:0]      rem_next;

   always_comb begin
      sum       = {1'b0, prod_ff[2*CW-1:CW]} + (prod_ff[0] ? {1'b0, a_ff} : {(CW+1){1'b0}});
      trial     = {prod_ff[2*CW-1:CW], prod_ff[CW-1]};
      trial_ext = CMPW'(trial);
      d_ext     = CMPW'(d_ff);
      ge        = (trial_ext >= d_ext);
      rem_next  = ge ? CW'(trial_ext - d_ext) : trial[CW-1:0];
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      a_in     = a_ff;
      d_in     = d_ff;
      done_in  = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (go) begin
               a_in     = a;
               d_in     = d;
               prod_in  = {{CW{1'b0}}, b};
               cnt_in   = '0;
               phase_in = PH_MUL;
            end
         end
         PH_MUL: begin
            prod_in = {sum, prod_ff[CW-1:1]};
            cnt_in  = CNTW'(cnt_ff + 1'b1);
            if (cnt_ff == CNTW'(CW - 1)) begin
               cnt_in   = '0;
               phase_in = PH_DIV;
            end
         end
         PH_DIV: begin
            // high half holds the partial remainder, low half collects quotient bits
            prod_in = {rem_next, prod_ff[CW-2:0], ge};
            cnt_in  = CNTW'(cnt_ff + 1'b1);
            if (cnt_ff == CNTW'(CW - 1)) begin
               cnt_in   = '0;
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      a_ff    <= a_in;
      d_ff    <= d_in;
   end

   assign quo           = prod_ff[CW-1:0];
   assign status.done   = done_ff;
   assign status.rem_nz = |prod_ff[2*CW-1:CW];

endmodule

// ===== rtl/three_axis_fixed_step_interpolator.sv =====
// Load: per-axis difference and magnitude, then a ceiling length divide (skipped when
// step_per_cycle is 0, which leaves no move), then ready again. Tick: each axis in turn
// through the serial multiply/divide unit shared by the axes; the final point of a move skips it.
// One item at a time; the result register lets the next item in while a point waits.
// Synchronous active-high reset: idle, no move, step_per_cycle = 1, output empty.
module three_axis_fixed_step_interpolator #(
   parameter int AXIS_COUNT  = tfsi_pkg::AXIS_COUNT_DEF,
   parameter int COUNT_WIDTH = tfsi_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         csr_wr_en,
   input  logic [tfsi_pkg::STEP_W-1:0]                  csr_wr_data,  // step_per_cycle
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // start_x, start_y, start_z, target_x, target_y, target_z
   input  logic [2*AXIS_COUNT*tfsi_pkg::FIELD_W-1:0]    req_tdata,
   input  logic                                         req_tuser,    // opcode
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   // point_x, point_y, point_z
   output logic [AXIS_COUNT*tfsi_pkg::FIELD_W-1:0]      rsp_tdata,
   output logic                                         rsp_tlast     // last
);
   import tfsi_pkg::*;

   localparam int CW  = COUNT_WIDTH;
   localparam int AXW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_DIFF  = 9'b000000010,
      ST_MAG   = 9'b000000100,
      ST_LGO   = 9'b000001000,
      ST_LEN   = 9'b000010000,
      ST_TICK  = 9'b000100000,
      ST_ISSUE = 9'b001000000,
      ST_PROD  = 9'b010000000,
      ST_EMIT  = 9'b100000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic signed [CW-1:0]          start_ff [AXIS_COUNT];
   logic signed [CW-1:0]          start_in [AXIS_COUNT];
   logic signed [CW-1:0]          tgt_ff [AXIS_COUNT];
   logic signed [CW-1:0]          tgt_in [AXIS_COUNT];
   logic [CW-1:0]                 mag_ff [AXIS_COUNT];
   logic [CW-1:0]                 mag_in [AXIS_COUNT];
   logic [AXIS_COUNT-1:0]         neg_ff, neg_in;
   logic signed [CW-1:0]          pt_ff [AXIS_COUNT];
   logic signed [CW-1:0]          pt_in [AXIS_COUNT];
   logic signed [CW:0]            diff_ff, diff_in;
   logic [CW-1:0]                 max_ff, max_in;
   logic [CW-1:0]                 len_ff, len_in;
   logic [CW-1:0]                 tick_ff, tick_in;
   logic                          moving_ff, moving_in;
   logic                          last_ff, last_in;
   logic [AXW-1:0]                axis_ff, axis_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [AXIS_COUNT*FIELD_W-1:0] rsp_data_ff, rsp_data_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          go;
   logic [CW-1:0]                 a_sel;
   logic [CW-1:0]                 b_sel;
   logic [FIELD_W-1:0]            d_sel;
   logic [CW-1:0]                 quo;
   mdv_status_type                mdv_status;
   logic [CW-1:0]                 mag_val;

   assign mag_val = diff_ff[CW] ? CW'(-diff_ff) : CW'(diff_ff);

   always_comb begin
      state_in     = state_ff;
      step_in      = csr_wr_en ? csr_wr_data : step_ff;
      start_in     = start_ff;
      tgt_in       = tgt_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      pt_in        = pt_ff;
      diff_in      = diff_ff;
      max_in       = max_ff;
      len_in       = len_ff;
      tick_in      = tick_ff;
      moving_in    = moving_ff;
      last_in      = last_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      go           = 1'b0;
      a_sel        = mag_ff[axis_ff];
      b_sel        = tick_ff;
      d_sel        = FIELD_W'(len_ff);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == OP_LOAD) begin
                  for (int i = 0; i < AXIS_COUNT; i++) begin
                     start_in[i] = req_tdata[i*FIELD_W +: CW];
                     tgt_in[i]   = req_tdata[(AXIS_COUNT+i)*FIELD_W +: CW];
                  end
                  tick_in   = '0;
                  max_in    = '0;
                  axis_in   = '0;
                  moving_in = 1'b0;
                  state_in  = ST_DIFF;
               end else if (moving_ff) begin
                  tick_in  = CW'(tick_ff + 1'b1);
                  state_in = ST_TICK;
               end
            end
         end
         ST_DIFF: begin
            diff_in  = (CW+1)'(tgt_ff[axis_ff]) - (CW+1)'(start_ff[axis_ff]);
            state_in = ST_MAG;
         end
         ST_MAG: begin
            mag_in[axis_ff] = mag_val;
            neg_in[axis_ff] = diff_ff[CW];
            if (mag_val > max_ff) begin
               max_in = mag_val;
            end
            if (axis_ff == AXW'(AXIS_COUNT - 1)) begin
               axis_in = '0;
               if (step_ff == '0) begin
                  len_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_LGO;
               end
            end else begin
               axis_in  = AXW'(axis_ff + 1'b1);
               state_in = ST_DIFF;
            end
         end
         ST_LGO: begin
            go       = 1'b1;
            a_sel    = max_ff;
            b_sel    = CW'(1);
            d_sel    = FIELD_W'(step_ff);
            state_in = ST_LEN;
         end
         ST_LEN: begin
            if (mdv_status.done) begin
               // ceiling, at least one
               if (quo == '0 && !mdv_status.rem_nz) begin
                  len_in = CW'(1);
               end else begin
                  len_in = CW'(quo + CW'(mdv_status.rem_nz));
               end
               moving_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_TICK: begin
            if (tick_ff >= len_ff) begin
               last_in   = 1'b1;
               moving_in = 1'b0;
               state_in  = ST_EMIT;
            end else begin
               last_in  = 1'b0;
               axis_in  = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            go       = 1'b1;
            state_in = ST_PROD;
         end
         ST_PROD: begin
            if (mdv_status.done) begin
               if (neg_ff[axis_ff]) begin
                  pt_in[axis_ff] = $unsigned(start_ff[axis_ff]) - quo;
               end else begin
                  pt_in[axis_ff] = $unsigned(start_ff[axis_ff]) + quo;
               end
               if (axis_ff == AXW'(AXIS_COUNT - 1)) begin
                  state_in = ST_EMIT;
               end else begin
                  axis_in  = AXW'(axis_ff + 1'b1);
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               for (int i = 0; i < AXIS_COUNT; i++) begin
                  rsp_data_in[i*FIELD_W +: FIELD_W] =
                     last_ff ? FIELD_W'(tgt_ff[i]) : FIELD_W'(pt_ff[i]);
               end
               rsp_last_in  = last_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_W'(1);
         moving_ff    <= 1'b0;
         len_ff       <= '0;
         tick_ff      <= '0;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         moving_ff    <= moving_in;
         len_ff       <= len_in;
         tick_ff      <= tick_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      tgt_ff      <= tgt_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      pt_ff       <= pt_in;
      diff_ff     <= diff_in;
      max_ff      <= max_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   tfsi_muldiv #(
      .CW(CW)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .go     (go),
      .a      (a_sel),
      .b      (b_sel),
      .d      (d_sel),
      .quo    (quo),
      .status (mdv_status)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/tfsi_checker.sv =====
// Port-level checks for the three-axis interpolator, bound to the top level.
// Uses tfsi_pkg and three_axis_fixed_step_interpolator_macros.svh.
`include "three_axis_fixed_step_interpolator_macros.svh"

module tfsi_checker #(
   parameter int AXIS_COUNT = tfsi_pkg::AXIS_COUNT_DEF
) (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_tvalid,
   input logic                                    req_tready,
   input logic                                    req_tuser,
   input logic                                    rsp_tvalid,
   input logic                                    rsp_tready,
   input logic [AXIS_COUNT*tfsi_pkg::FIELD_W-1:0] rsp_tdata,
   input logic                                    rsp_tlast
);
   import tfsi_pkg::*;

   `TFSI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled transfer changed")
   `TFSI_ASSERT_NEXT(a_load_busy, clock, reset, req_tvalid && req_tready && req_tuser == OP_LOAD, !req_tready, "load did not start length work")
   `TFSI_ASSERT_SAME(a_rsp_from_busy, clock, reset, $rose(rsp_tvalid), !$past(req_tready), "point appeared while idle")

endmodule

bind three_axis_fixed_step_interpolator tfsi_checker #(
   .AXIS_COUNT(AXIS_COUNT)
) u_tfsi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== sim/three_axis_fixed_step_interpolator_tb.sv =====
// Self-checking bench for three_axis_fixed_step_interpolator: a directed table checked against
// its own expected points, then random load/tick traffic with random idling, checked against a local interpolator.
// Depends on tfsi_pkg and the interpolator RTL; needs nothing else.
module three_axis_fixed_step_interpolator_tb;
   import tfsi_pkg::*;

   localparam int REQ_W = 2 * AXIS_COUNT_DEF * FIELD_W;
   localparam int RSP_W = AXIS_COUNT_DEF * FIELD_W;
   localparam int SETTLE_CYCLES = 300;
   localparam int RSP_HOLD_CYCLES = 1500;
   localparam int STALL_LIMIT = 20000;
   localparam logic [STEP_W-1:0] STEP_MAX = '1;
   localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
   localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
   localparam longint CNT_HI = 64'sd2147483647;
   localparam longint CNT_LO = -64'sd2147483648;

   typedef struct packed {
      logic [31:0] point_x;
      logic [31:0] point_y;
      logic [31:0] point_z;
      logic        last;
   } axis_point_type;

   typedef enum {PLAN_STEP, PLAN_ITEM} plan_kind_type;

   typedef struct {
      plan_kind_type     kind;
      logic [STEP_W-1:0] step;
      logic              op;
      logic [REQ_W-1:0]  data;
      bit                typed;
      bit                typed_has;
      axis_point_type    typed_pt;
   } plan_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [STEP_W-1:0] csr_wr_data = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              req_tuser = OP_TICK;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              rsp_tlast;

   three_axis_fixed_step_interpolator dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // interpolator mirror
   logic [STEP_W-1:0]  step_cfg = 1;
   logic signed [31:0] move_start [3] = '{default: 0};
   logic signed [31:0] move_target [3] = '{default: 0};
   logic signed [32:0] move_delta [3] = '{default: 0};
   logic [31:0]        move_len = 0;
   logic [31:0]        move_tick = 0;
   bit                 in_motion = 1'b0;

   axis_point_type pending_points [$];
   plan_row_type   plan [$];
   int             fail_count = 0;
   int             work_items = 0;
   int             send_idle = 0;
   int             recv_idle = 0;
   int             stalled_cycles = 0;
   int             hold_left = 0;
   bit             hold_request = 1'b0;

   function automatic longint unsigned delta_size(logic signed [32:0] d);
      longint sd;
      sd = d;
      return (sd < 0) ? -sd : sd;
   endfunction

   function automatic bit advance_interpolator(input logic op, input logic [REQ_W-1:0] data,
                                               output axis_point_type pt);
      longint unsigned peak, len, quot;
      logic [31:0] res [3];
      pt = '0;
      if (op == OP_LOAD) begin
         peak = 0;
         for (int a = 0; a < 3; a++) begin
            move_start[a] = data[a*FIELD_W +: FIELD_W];
            move_target[a] = data[(3+a)*FIELD_W +: FIELD_W];
            move_delta[a] = {move_target[a][31], move_target[a]} -
                            {move_start[a][31], move_start[a]};
            if (delta_size(move_delta[a]) > peak) peak = delta_size(move_delta[a]);
         end
         move_tick = 0;
         if (step_cfg == 0) begin
            move_len = 0;
            in_motion = 1'b0;
            return 1'b0;
         end
         len = (peak + step_cfg - 1) / step_cfg;
         if (len < 1) len = 1;
         move_len = len[31:0];
         in_motion = 1'b1;
         return 1'b0;
      end
      if (!in_motion || move_len == 0) return 1'b0;
      move_tick++;
      if (move_tick >= move_len) begin
         in_motion = 1'b0;
         pt = '{move_target[0], move_target[1], move_target[2], 1'b1};
         return 1'b1;
      end
      for (int a = 0; a < 3; a++) begin
         quot = (delta_size(move_delta[a]) * move_tick) / move_len;
         res[a] = move_delta[a][32] ? move_start[a] - quot[31:0] : move_start[a] + quot[31:0];
      end
      pt = '{res[0], res[1], res[2], 1'b0};
      return 1'b1;
   endfunction

   function automatic plan_row_type item_row(logic op, logic [REQ_W-1:0] data, bit typed,
                                             bit has, axis_point_type pt);
      plan_row_type r;
      r.kind = PLAN_ITEM;
      r.step = '0;
      r.op = op;
      r.data = data;
      r.typed = typed;
      r.typed_has = has;
      r.typed_pt = pt;
      return r;
   endfunction

   function automatic plan_row_type step_row(logic [STEP_W-1:0] v);
      plan_row_type r;
      r = item_row(OP_TICK, '0, 1'b0, 1'b0, '0);
      r.kind = PLAN_STEP;
      r.step = v;
      return r;
   endfunction

   function automatic plan_row_type load_row(logic signed [31:0] sx, sy, sz, tx, ty, tz);
      return item_row(OP_LOAD, {tz, ty, tx, sz, sy, sx}, 1'b1, 1'b0, '0);
   endfunction

   function automatic plan_row_type tick_row();
      return item_row(OP_TICK, '0, 1'b0, 1'b0, '0);
   endfunction

   function automatic plan_row_type tick_idle();
      return item_row(OP_TICK, '1, 1'b1, 1'b0, '0);
   endfunction

   function automatic plan_row_type tick_point(logic signed [31:0] x, y, z, logic l);
      return item_row(OP_TICK, '0, 1'b1, 1'b1, '{x, y, z, l});
   endfunction

   function automatic logic [REQ_W-1:0] random_item_data();
      logic [REQ_W-1:0] d;
      for (int w = 0; w < REQ_W / 32; w++) d[w*32 +: 32] = $urandom;
      return d;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
         $error("%s: expected 0x%08h, actual 0x%08h", name, want, seen);
         fail_count++;
      end
   endfunction

   task automatic push_item(input logic op, input logic [REQ_W-1:0] data,
                            input bit typed = 1'b0, input bit typed_has = 1'b0,
                            input axis_point_type typed_pt = '0);
      axis_point_type pt;
      bit got;
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= data;
      do @(posedge clock); while (req_tready !== 1'b1);
      got = advance_interpolator(op, data, pt);
      if (typed) begin
         got = typed_has;
         pt = typed_pt;
      end
      if (got) pending_points = {pending_points, pt};
      if (op == OP_LOAD || got) work_items++;
   endtask

   task automatic drain_points();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_step(input logic [STEP_W-1:0] v);
      drain_points();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      step_cfg = v;
   endtask

   // result side: random back-pressure plus a long hold-off on each request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = RSP_HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      axis_point_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_points.size() == 0) begin
            $error("point with no transfer pending: x=0x%08h y=0x%08h z=0x%08h last=%0b",
                   rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tlast);
            fail_count++;
         end else begin
            want = pending_points.pop_front();
            compare_field("point_x", want.point_x, rsp_tdata[31:0]);
            compare_field("point_y", want.point_y, rsp_tdata[63:32]);
            compare_field("point_z", want.point_z, rsp_tdata[95:64]);
            compare_field("last", {31'b0, want.last}, {31'b0, rsp_tlast});
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stalled_cycles = 0;
      else stalled_cycles++;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int r, n;
      longint lim, mag, t;
      logic signed [31:0] sv [3];
      logic signed [31:0] tv [3];
      logic [STEP_W-1:0] stp;

      plan = {plan, tick_idle()};
      plan = {plan, load_row(0, 0, 0, 0, 0, 0)};
      plan = {plan, tick_point(0, 0, 0, 1'b1)};
      plan = {plan, tick_idle()};
      plan = {plan, load_row(MIN32, MAX32, 0, MAX32, MIN32, 0)};
      plan = {plan, tick_point(MIN32 + 1, MAX32 - 1, 0, 1'b0)};
      plan = {plan, tick_row()};
      plan = {plan, load_row(10, 20, 30, 13, 20, 27)};
      plan = {plan, tick_point(11, 20, 29, 1'b0)};
      plan = {plan, tick_point(12, 20, 28, 1'b0)};
      plan = {plan, tick_point(13, 20, 27, 1'b1)};
      plan = {plan, tick_idle()};
      plan = {plan, step_row(STEP_MAX)};
      plan = {plan, load_row(MIN32, MIN32, MAX32, MAX32, MAX32, MIN32)};
      plan = {plan, tick_row()};
      plan = {plan, tick_row()};
      plan = {plan, tick_point(MAX32, MAX32, MIN32, 1'b1)};
      plan = {plan, step_row(0)};
      plan = {plan, load_row(1, 2, 3, 100, 200, 300)};
      plan = {plan, tick_idle()};
      plan = {plan, step_row(5)};
      plan = {plan, tick_idle()};
      plan = {plan, load_row(-7, 1000, -1, -7, 1000, -1)};
      plan = {plan, tick_point(-7, 1000, -1, 1'b1)};
      plan = {plan, load_row(100, -50, 0, 77, -50, 12)};
      repeat (4) plan = {plan, tick_row()};
      plan = {plan, tick_point(77, -50, 12, 1'b1)};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle = 23;
      recv_idle = 57;
      foreach (plan[i]) begin
         if (plan[i].kind == PLAN_STEP) write_step(plan[i].step);
         else push_item(plan[i].op, plan[i].data, plan[i].typed, plan[i].typed_has,
                        plan[i].typed_pt);
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 23 : (phase == 1) ? 57 : 0;
         recv_idle = (phase == 0) ? 57 : (phase == 1) ? 23 : 0;
         while (work_items < 27 + (phase + 1) * 241) begin
            case ($urandom_range(4))
               0: stp = STEP_W'(1);
               1: stp = STEP_MAX;
               2: stp = STEP_W'($urandom_range(20, 2));
               3: stp = STEP_W'($urandom_range(100000, 21));
               default: begin
                  stp = STEP_W'($urandom);
                  if (stp == 0) stp = STEP_W'(1);
               end
            endcase
            write_step(stp);
            if (phase == 2 && work_items < 27 + 2 * 241 + 20) hold_request = 1'b1;
            for (int sq = 0; sq < 12; sq++) begin
               r = (sq == 0) ? 0 : $urandom_range(99);
               if (r < 75) begin
                  lim = longint'(step_cfg) * $urandom_range(10, (r == 0) ? 10 : 1);
                  if (lim > 64'sh0_FFFF_FFFF) lim = 64'sh0_FFFF_FFFF;
                  for (int a = 0; a < 3; a++) begin
                     sv[a] = $urandom;
                     mag = $urandom_range(lim[31:0], 0);
                     t = longint'(sv[a]) + ($urandom_range(1) ? mag : -mag);
                     if (t > CNT_HI || t < CNT_LO) t = 2 * longint'(sv[a]) - t;
                     if (t > CNT_HI) t = CNT_HI;
                     if (t < CNT_LO) t = CNT_LO;
                     tv[a] = t[31:0];
                  end
                  push_item(OP_LOAD, {tv[2], tv[1], tv[0], sv[2], sv[1], sv[0]});
                  case ($urandom_range(9))
                     7: n = move_len + 1;
                     8, 9: n = $urandom_range(move_len - 1, 0);
                     default: n = move_len;
                  endcase
                  repeat (n) push_item(OP_TICK, random_item_data());
               end else begin
                  repeat ($urandom_range(4, 1))
                     push_item(1'($urandom_range(1)), random_item_data());
               end
            end
         end
      end

      drain_points();
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
